// ===== rtl/occupancy_grid_clearance_core_defines.svh =====
// Assertion helpers used by the checker file.
`ifndef OCCUPANCY_GRID_CLEARANCE_CORE_DEFINES_SVH
`define OCCUPANCY_GRID_CLEARANCE_CORE_DEFINES_SVH

// Clocked check, off while reset is asserted.
`define OGC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked check that also holds while reset is asserted.
`define OGC_ASSERT_RST(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/ogc_pkg.sv =====
`timescale 1ns / 1ps

package ogc_pkg;

	localparam int AXIS_CELLS = 64;
	localparam int MAX_RADIUS = 15;

	// bitmap geometry: one row holds all cells along the first axis
	localparam int AXW    = $clog2(AXIS_CELLS);
	localparam int ROW_AW = 2 * AXW;
	localparam int ROWS   = 1 << ROW_AW;

	// fixed field widths
	localparam int OP_W    = 2;
	localparam int CW      = 8;
	localparam int MR_W    = 4;
	localparam int CLR_W   = 4;
	localparam int COUNT_W = 19;
	localparam int SIZE_W  = 7;
	localparam int CFG_IDX_W = 2;

	// radius and offset widths
	localparam int RW  = $clog2(MAX_RADIUS + 1);
	localparam int DW  = RW + 1;
	localparam int MRW = (RW > MR_W) ? RW : MR_W;
	localparam int SW  = ((CW > DW) ? CW : DW) + 1;
	localparam int EW  = $clog2(AXIS_CELLS + 1);
	localparam int CMW = ((SW - 1) > EW) ? (SW - 1) : EW;
	localparam int SXW = (SIZE_W > EW) ? SIZE_W : EW;

	localparam logic [RW-1:0] RMAX = RW'(MAX_RADIUS);

	localparam logic [OP_W-1:0] OP_QUERY     = 2'd0;
	localparam logic [OP_W-1:0] OP_MARK      = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEARANCE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_SIZE_I = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_J = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_K = 2'd2;

	localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

	typedef struct packed {
		logic [OP_W-1:0]      op;
		logic signed [CW-1:0] coord_i;
		logic signed [CW-1:0] coord_j;
		logic signed [CW-1:0] coord_k;
		logic [MR_W-1:0]      search_radius;
	} req_t;

	typedef struct packed {
		logic               blocked;
		logic [CLR_W-1:0]   clearance;
		logic [COUNT_W-1:0] blocked_count;
	} rsp_t;

	typedef struct packed {
		logic signed [DW-1:0] di;
		logic signed [DW-1:0] dj;
		logic signed [DW-1:0] dk;
	} offset_t;

	typedef struct packed {
		logic [EW-1:0] i;
		logic [EW-1:0] j;
		logic [EW-1:0] k;
	} extent_t;

	typedef struct packed {
		logic              in_bounds;
		logic [ROW_AW-1:0] row;
		logic [AXW-1:0]    col;
	} loc_t;

	typedef struct packed {
		logic                  en;
		logic [ROW_AW-1:0]     addr;
		logic [AXIS_CELLS-1:0] data;
	} wr_t;

	// size register clamped to the storage extent
	function automatic logic [EW-1:0] eff_size(input logic [SIZE_W-1:0] s);
		logic [SXW-1:0] sx;
		sx = SXW'(s);
		if (sx > SXW'(AXIS_CELLS)) begin
			return EW'(AXIS_CELLS);
		end
		return EW'(sx);
	endfunction

endpackage

// ===== rtl/ogc_addr.sv =====
`timescale 1ns / 1ps

module ogc_addr (
	input  ogc_pkg::req_t    ctr,
	input  ogc_pkg::offset_t ofs,
	input  ogc_pkg::extent_t lim,
	output ogc_pkg::loc_t    loc
);
	import ogc_pkg::*;

	logic signed [SW-1:0] si;
	logic signed [SW-1:0] sj;
	logic signed [SW-1:0] sk;

	function automatic logic axis_in(input logic signed [SW-1:0] s, input logic [EW-1:0] n);
		logic [CMW-1:0] mag;
		logic [CMW-1:0] top;
		mag = CMW'(s[SW-2:0]);
		top = CMW'(n);
		return !s[SW-1] && (mag < top);
	endfunction

	// shared add-and-bound unit: centre plus offset on each axis
	always_comb begin
		si = SW'(ctr.coord_i) + SW'(ofs.di);
		sj = SW'(ctr.coord_j) + SW'(ofs.dj);
		sk = SW'(ctr.coord_k) + SW'(ofs.dk);
		loc.in_bounds = axis_in(si, lim.i) && axis_in(sj, lim.j) && axis_in(sk, lim.k);
		loc.row       = {sk[AXW-1:0], sj[AXW-1:0]};
		loc.col       = si[AXW-1:0];
	end

endmodule

// ===== rtl/ogc_bitmap.sv =====
`timescale 1ns / 1ps

module ogc_bitmap (
	input  logic                           clk,
	input  ogc_pkg::wr_t                   wr,
	input  logic [ogc_pkg::ROW_AW-1:0]     raddr,
	output logic [ogc_pkg::AXIS_CELLS-1:0] rdata
);
	import ogc_pkg::*;

	logic [AXIS_CELLS-1:0] mem_q [ROWS];
	logic [AXIS_CELLS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem_q[wr.addr] <= wr.data;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/occupancy_grid_clearance_core.sv =====
`timescale 1ns / 1ps

// 3D occupancy bitmap with Manhattan clearance search. After reset the block
// sweeps the bitmap clear, one row of AXIS_CELLS cells per cycle, over all
// ROWS (4096) rows; req_stall stays high during the sweep while size writes on
// the configuration port are taken. A query or mark then passes through a
// bitmap row read, a check (and, for a mark, the row write-back) and a result
// state that holds until the output register is free, after which the block
// is back in idle and takes the next transaction. A clearance search runs the
// same centre check, then walks the shells r = 1 up to the requested radius
// (capped at MAX_RADIUS) one cell at a time through the shared coordinate
// adder and bound compare: a row read and a bit check for each in-grid
// neighbour, while a neighbour outside the grid is skipped without a read,
// stopping at the first blocked cell. A finished result sits in the output
// register, so the next transaction is taken while it waits to be drained.
module occupancy_grid_clearance_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               req_valid,
	output logic                               req_stall,
	input  ogc_pkg::req_t                      req,
	output logic                               rsp_valid,
	input  logic                               rsp_stall,
	output ogc_pkg::rsp_t                      rsp,
	input  logic                               cfg_we,
	input  logic [ogc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ogc_pkg::SIZE_W-1:0]         cfg_data
);
	import ogc_pkg::*;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_CTR_RD,
		ST_CTR_CHK,
		ST_NB_ADDR,
		ST_NB_CHK,
		ST_FIN
	} state_t;

	state_t               state_q;
	logic [ROW_AW-1:0]    clr_row_q;
	logic [SIZE_W-1:0]    size_i_q;
	logic [SIZE_W-1:0]    size_j_q;
	logic [SIZE_W-1:0]    size_k_q;
	req_t                 item_q;
	logic [RW-1:0]        mr_q;
	logic [RW-1:0]        r_q;
	logic signed [DW-1:0] di_q;
	logic signed [DW-1:0] dj_q;
	logic                 dkpos_q;
	logic [COUNT_W-1:0]   count_q;
	logic                 res_blocked_q;
	logic [RW-1:0]        res_clr_q;
	logic                 rsp_valid_q;
	rsp_t                 rsp_q;

	extent_t               lim;
	offset_t               ofs;
	loc_t                  loc;
	wr_t                   wr;
	logic [AXIS_CELLS-1:0] row_data;
	logic                  bit_set;
	logic                  ctr_blocked;
	logic                  do_mark;
	logic                  rsp_load;
	logic [MRW-1:0]        mr_ext;
	logic [RW-1:0]         mr_in;

	// shell walk
	logic signed [DW-1:0] r_s;
	logic signed [DW-1:0] rem1;
	logic signed [DW-1:0] rem2;
	logic signed [DW-1:0] di_p1;
	logic [RW-1:0]        r_inc;
	logic                 last_cell;
	logic [RW-1:0]        nx_r;
	logic signed [DW-1:0] nx_di;
	logic signed [DW-1:0] nx_dj;
	logic                 nx_dkpos;

	function automatic logic signed [DW-1:0] sabs(input logic signed [DW-1:0] v);
		return v[DW-1] ? -v : v;
	endfunction

	assign lim.i = eff_size(size_i_q);
	assign lim.j = eff_size(size_j_q);
	assign lim.k = eff_size(size_k_q);

	always_comb begin
		r_s   = $signed({1'b0, r_q});
		rem1  = r_s - sabs(di_q);
		rem2  = rem1 - sabs(dj_q);
		di_p1 = di_q + DW'(1);
		r_inc = r_q + RW'(1);
		last_cell = (di_q == r_s) && (r_q == mr_q);

		nx_r     = r_q;
		nx_di    = di_q;
		nx_dj    = dj_q;
		nx_dkpos = 1'b0;
		priority if (!dkpos_q && (rem2 != '0)) begin
			nx_dkpos = 1'b1;
		end else if (dj_q < rem1) begin
			nx_dj = dj_q + DW'(1);
		end else if (di_q < r_s) begin
			nx_di = di_p1;
			nx_dj = -(r_s - sabs(di_p1));
		end else begin
			// open the next shell at its single cell on the negative first axis
			nx_r  = r_inc;
			nx_di = -$signed({1'b0, r_inc});
			nx_dj = '0;
		end

		if ((state_q == ST_NB_ADDR) || (state_q == ST_NB_CHK)) begin
			ofs.di = di_q;
			ofs.dj = dj_q;
			ofs.dk = dkpos_q ? rem2 : -rem2;
		end else begin
			ofs = '0;
		end
	end

	ogc_addr u_addr (
		.ctr (item_q),
		.ofs (ofs),
		.lim (lim),
		.loc (loc)
	);

	assign bit_set     = row_data[loc.col];
	assign ctr_blocked = !loc.in_bounds || bit_set;
	assign do_mark     = (state_q == ST_CTR_CHK) && (item_q.op == OP_MARK) &&
		loc.in_bounds && !bit_set;
	assign rsp_load    = (state_q == ST_FIN) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr.en   = 1'b1;
			wr.addr = clr_row_q;
			wr.data = '0;
		end else begin
			wr.en   = do_mark;
			wr.addr = loc.row;
			wr.data = row_data | (AXIS_CELLS'(1) << loc.col);
		end
	end

	ogc_bitmap u_bitmap (
		.clk   (clk),
		.wr    (wr),
		.raddr (loc.row),
		.rdata (row_data)
	);

	always_comb begin
		mr_ext = MRW'(req.search_radius);
		mr_in  = (mr_ext > MRW'(MAX_RADIUS)) ? RMAX : RW'(mr_ext);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_CLEAR;
			clr_row_q     <= '0;
			size_i_q      <= SIZE_RESET;
			size_j_q      <= SIZE_RESET;
			size_k_q      <= SIZE_RESET;
			item_q        <= '0;
			mr_q          <= '0;
			r_q           <= '0;
			di_q          <= '0;
			dj_q          <= '0;
			dkpos_q       <= 1'b0;
			count_q       <= '0;
			res_blocked_q <= 1'b0;
			res_clr_q     <= '0;
			rsp_valid_q   <= 1'b0;
			rsp_q         <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SIZE_I: size_i_q <= cfg_data;
					REG_SIZE_J: size_j_q <= cfg_data;
					REG_SIZE_K: size_k_q <= cfg_data;
					default: ;
				endcase
			end

			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_CLEAR: begin
					clr_row_q <= clr_row_q + ROW_AW'(1);
					if (clr_row_q == '1) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_valid) begin
						item_q  <= req;
						mr_q    <= mr_in;
						state_q <= ST_CTR_RD;
					end
				end
				ST_CTR_RD: begin
					state_q <= ST_CTR_CHK;
				end
				ST_CTR_CHK: begin
					res_clr_q <= '0;
					unique case (item_q.op)
						OP_MARK: begin
							if (do_mark) begin
								count_q <= count_q + COUNT_W'(1);
							end
							res_blocked_q <= 1'b1;
							state_q       <= ST_FIN;
						end
						OP_CLEARANCE: begin
							res_blocked_q <= ctr_blocked;
							if ((mr_q == '0) || ctr_blocked) begin
								state_q <= ST_FIN;
							end else begin
								r_q     <= RW'(1);
								di_q    <= -DW'(1);
								dj_q    <= '0;
								dkpos_q <= 1'b0;
								state_q <= ST_NB_ADDR;
							end
						end
						default: begin
							res_blocked_q <= ctr_blocked;
							state_q       <= ST_FIN;
						end
					endcase
				end
				ST_NB_ADDR: begin
					// skip neighbors outside the grid without a read
					if (loc.in_bounds) begin
						state_q <= ST_NB_CHK;
					end else if (last_cell) begin
						res_clr_q <= mr_q;
						state_q   <= ST_FIN;
					end else begin
						r_q     <= nx_r;
						di_q    <= nx_di;
						dj_q    <= nx_dj;
						dkpos_q <= nx_dkpos;
					end
				end
				ST_NB_CHK: begin
					if (bit_set) begin
						res_clr_q <= r_q - RW'(1);
						state_q   <= ST_FIN;
					end else if (last_cell) begin
						res_clr_q <= mr_q;
						state_q   <= ST_FIN;
					end else begin
						r_q     <= nx_r;
						di_q    <= nx_di;
						dj_q    <= nx_dj;
						dkpos_q <= nx_dkpos;
						state_q <= ST_NB_ADDR;
					end
				end
				ST_FIN: begin
					// hold until the output register is free
					if (rsp_load) begin
						rsp_q.blocked       <= res_blocked_q;
						rsp_q.clearance     <= CLR_W'(MRW'(res_clr_q));
						rsp_q.blocked_count <= count_q;
						state_q             <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_stall = (state_q != ST_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/ogc_checker.sv =====
`timescale 1ns / 1ps
`include "occupancy_grid_clearance_core_defines.svh"

module ogc_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          req_valid,
	input logic          req_stall,
	input logic          rsp_valid,
	input logic          rsp_stall,
	input ogc_pkg::rsp_t rsp
);
	import ogc_pkg::*;

	`OGC_ASSERT_RST(a_reset_quiet, !arst_n |-> req_stall && !rsp_valid, "busy or valid in reset")
	`OGC_ASSERT(a_busy_after_accept, req_valid && !req_stall |=> req_stall, "accepted twice in a row")
	`OGC_ASSERT(a_rsp_hold, rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp), "stalled result moved")
	`OGC_ASSERT(a_clear_means_free, rsp_valid && (rsp.clearance != '0) |-> !rsp.blocked, "clearance on blocked cell")
	`OGC_ASSERT(a_count_step, rsp_valid && $past(rsp_valid) |-> (rsp.blocked_count == $past(rsp.blocked_count)) || (rsp.blocked_count == $past(rsp.blocked_count) + COUNT_W'(1)), "count jumped")

endmodule

bind occupancy_grid_clearance_core ogc_checker u_ogc_checker (.*);
